// File: rtl/core/szaq_pkg.sv
// Shared types, codes and constants of the sensor zone alarm qualifier.
package szaq_pkg;

  localparam int CFG_W   = 19;
  localparam int THR_W   = 11;
  localparam int DEB_W   = 5;
  localparam int EN_W    = 2;
  localparam int HIT_W   = 4;
  localparam int MAG_W   = 12;
  localparam int TEMP_W  = 12;
  localparam int PROX_W  = 10;
  localparam int ALS_W   = 16;
  localparam int IR_W    = 10;
  localparam int ACC_W   = 16;
  localparam int AXIS_W  = 11;
  localparam int VAL_W   = 17;

  localparam int PROD_W  = 31;
  localparam int SUM_W   = 32;
  localparam int RAD_W   = 46;
  localparam int ROOT_W  = 23;
  localparam int SREM_W  = 25;
  localparam int TNUM_W  = 24;
  localparam int DIV_W   = 23;
  localparam int TQ_PROD_W = 42;
  localparam int TQ_SHIFT  = 30;
  localparam int MAG_SHIFT = 11;

  localparam int SQ_STEPS   = 4;
  localparam int ROOT_STEPS = 23;

  localparam logic [THR_W-1:0]  THR_MAX    = 11'd2000;
  localparam logic [DEB_W-1:0]  DEB_MIN    = 5'd1;
  localparam logic [DEB_W-1:0]  DEB_MAX    = 5'd20;
  localparam logic [DEB_W-1:0]  DEB_RESET  = 5'd2;
  localparam logic [EN_W-1:0]   EN_RESET   = 2'b11;
  localparam logic [CFG_W-1:0]  ZONE0_RESET = 19'd327710;
  localparam logic [CFG_W-1:0]  ZONE3_RESET = 19'd393366;
  localparam logic [MAG_W-1:0]  MAG_MAX    = 12'd2772;

  localparam logic [13:0]        MAG_SCALE   = 14'd10000;
  // divide by 3268 as a divide by 4, then multiply by ceil(2^30 / 817) and shift
  localparam logic [20:0]        TQ_RECIP    = 21'd1314250;
  localparam logic signed [TNUM_W-1:0] TEMP_GAIN   = 24'sd100;
  localparam logic signed [TNUM_W-1:0] TEMP_OFFSET = 24'sd817000;
  localparam logic [23:0]        AXIS_GAIN   = 24'd100;

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_LIGHT  = 2'd1;
  localparam logic [1:0] SRC_MOTION = 2'd2;
  localparam logic [1:0] SRC_BAD    = 2'd3;

  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_EQ = 2'd2;

  localparam logic [2:0] CH_PROX = 3'd0;
  localparam logic [2:0] CH_ALS  = 3'd1;
  localparam logic [2:0] CH_AX   = 3'd1;
  localparam logic [2:0] CH_AY   = 3'd2;
  localparam logic [2:0] CH_AZ   = 3'd3;
  localparam logic [2:0] CH_TEMP = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic EN_BIT_LIGHT  = 1'b0;
  localparam logic EN_BIT_MOTION = 1'b1;

  typedef struct packed {
    logic             enable;
    logic [1:0]       source;
    logic [2:0]       channel;
    logic [1:0]       compare;
    logic [THR_W-1:0] threshold;
  } zone_set_t;

  typedef struct packed {
    logic       load;
    logic       sq_mul;
    logic       sq_acc;
    logic [1:0] sq_sel;
    logic       scale;
    logic       root_step;
    logic       eval;
  } szaq_cmd_t;

  typedef struct packed {
    logic out_full;
  } szaq_sts_t;

  function automatic zone_set_t zone_reset_value(input int z);
    zone_set_t v;
    v = zone_set_t'(ZONE0_RESET);
    if (z == 0) begin
      v = zone_set_t'(ZONE0_RESET);
    end else if (z == 3) begin
      v = zone_set_t'(ZONE3_RESET);
    end else begin
      v = zone_set_t'({CFG_W{1'b0}});
    end
    return v;
  endfunction

endpackage

// File: rtl/core/szaq_cfg.sv
// Configuration register file with write-time saturation of fields.
module szaq_cfg #(
  parameter int ZONE_COUNT = 4,
  parameter int IDX_W      = 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [IDX_W-1:0]                       cfg_index,
  input  logic [szaq_pkg::CFG_W-1:0]             cfg_data,
  output szaq_pkg::zone_set_t [ZONE_COUNT-1:0]   zone_set,
  output logic [szaq_pkg::DEB_W-1:0]             hit_debounce,
  output logic [szaq_pkg::EN_W-1:0]              sensor_enables
);
  import szaq_pkg::*;

  localparam logic [IDX_W-1:0] IDX_DEB = IDX_W'(ZONE_COUNT);
  localparam logic [IDX_W-1:0] IDX_EN  = IDX_W'(ZONE_COUNT + 1);

  zone_set_t [ZONE_COUNT-1:0] zone_r;
  logic [DEB_W-1:0]           deb_r;
  logic [EN_W-1:0]            en_r;
  logic                       wr;
  zone_set_t                  zone_clean;
  logic [DEB_W-1:0]           deb_clean;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_comb begin
    zone_clean = zone_set_t'(cfg_data);
    if (zone_clean.threshold > THR_MAX) begin
      zone_clean.threshold = THR_MAX;
    end
    if (zone_clean.source == SRC_BAD) begin
      zone_clean.source = SRC_MOTION;
    end
    deb_clean = cfg_data[DEB_W-1:0];
    if (deb_clean < DEB_MIN) begin
      deb_clean = DEB_MIN;
    end else if (deb_clean > DEB_MAX) begin
      deb_clean = DEB_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        zone_r[z] <= zone_reset_value(z);
      end
      deb_r <= DEB_RESET;
      en_r  <= EN_RESET;
    end else if (wr) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        if (cfg_index == IDX_W'(z)) begin
          zone_r[z] <= zone_clean;
        end
      end
      if (cfg_index == IDX_DEB) begin
        deb_r <= deb_clean;
      end
      if (cfg_index == IDX_EN) begin
        en_r <= cfg_data[EN_W-1:0];
      end
    end
  end

  assign zone_set       = zone_r;
  assign hit_debounce   = deb_r;
  assign sensor_enables = en_r;

endmodule

// File: rtl/core/szaq_ctrl.sv
// Sequencing state machine: square, scale, root and evaluate phases.
module szaq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  szaq_pkg::szaq_sts_t   sts,
  output logic                  in_stall,
  output szaq_pkg::szaq_cmd_t   cmd
);
  import szaq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SCALE,
    S_ROOT,
    S_EVAL
  } state_t;

  localparam logic [4:0] SQ_LAST   = 5'(SQ_STEPS - 1);
  localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);

  state_t     state_r;
  logic [4:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin
            state_r <= in_mode ? S_SQUARE : S_EVAL;
          end
        end
        S_SQUARE: begin
          if (cnt_r == SQ_LAST) begin
            state_r <= S_SCALE;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SCALE: begin
          state_r <= S_ROOT;
          cnt_r   <= '0;
        end
        S_ROOT: begin
          if (cnt_r == ROOT_LAST) begin
            state_r <= S_EVAL;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_EVAL: begin
          if (!sts.out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.sq_mul    = (state_r == S_SQUARE) && (cnt_r != SQ_LAST);
    cmd.sq_acc    = (state_r == S_SQUARE) && (cnt_r != 5'd0);
    cmd.sq_sel    = cnt_r[1:0];
    cmd.scale     = (state_r == S_SCALE);
    cmd.root_step = (state_r == S_ROOT);
    cmd.eval      = (state_r == S_EVAL) && !sts.out_full;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: rtl/core/szaq_dp.sv
// Datapath: capture, sum of squares, scaling, root and divide units, zone evaluation.
module szaq_dp #(
  parameter int ZONE_COUNT = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  szaq_pkg::szaq_cmd_t                   cmd,
  output szaq_pkg::szaq_sts_t                   sts,
  input  szaq_pkg::zone_set_t [ZONE_COUNT-1:0]  zone_set,
  input  logic [szaq_pkg::DEB_W-1:0]            hit_debounce,
  input  logic [szaq_pkg::EN_W-1:0]             sensor_enables,
  input  logic                                  in_mode,
  input  logic [szaq_pkg::PROX_W-1:0]           in_proximity,
  input  logic [szaq_pkg::ALS_W-1:0]            in_ambient_light,
  input  logic [szaq_pkg::IR_W-1:0]             in_infrared,
  input  logic signed [szaq_pkg::ACC_W-1:0]     in_accel_x,
  input  logic signed [szaq_pkg::ACC_W-1:0]     in_accel_y,
  input  logic signed [szaq_pkg::ACC_W-1:0]     in_accel_z,
  input  logic signed [szaq_pkg::ACC_W-1:0]     in_temp_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [szaq_pkg::HIT_W-1:0]            out_zone_hits,
  output logic [szaq_pkg::MAG_W-1:0]            out_magnitude_x100,
  output logic signed [szaq_pkg::TEMP_W-1:0]    out_temperature_x10
);
  import szaq_pkg::*;

  localparam int PW = (ZONE_COUNT > HIT_W) ? ZONE_COUNT : HIT_W;

  logic                     mode_r;
  logic [PROX_W-1:0]        prox_r;
  logic [ALS_W-1:0]         als_r;
  logic [IR_W-1:0]          ir_r;
  logic signed [ACC_W-1:0]  ax_r;
  logic signed [ACC_W-1:0]  ay_r;
  logic signed [ACC_W-1:0]  az_r;
  logic signed [ACC_W-1:0]  tr_r;

  logic signed [ACC_W-1:0]  sq_op;
  logic signed [SUM_W-1:0]  sq_prod;
  logic [PROD_W-1:0]        prod_r;
  logic [SUM_W-1:0]         acc_r;

  logic [RAD_W-1:0]         rad_scaled;
  logic [RAD_W-1:0]         rad_r;
  logic [SREM_W-1:0]        srem_r;
  logic [ROOT_W-1:0]        root_r;
  logic [SREM_W+1:0]        srem_sh;
  logic [SREM_W+1:0]        strial;
  logic                     sge;

  logic signed [TNUM_W-1:0] tnum;
  logic [TNUM_W-1:0]        tabs;
  logic                     tneg_r;
  logic [DIV_W-1:0]         tabs_r;
  logic [TQ_PROD_W-1:0]     tq_prod;
  logic [TEMP_W-1:0]        tq_r;

  logic [AXIS_W-1:0]        axa_r;
  logic [AXIS_W-1:0]        aya_r;
  logic [AXIS_W-1:0]        aza_r;

  logic [MAG_W-1:0]         mag_val;
  logic [TEMP_W-1:0]        temp_q;
  logic [TEMP_W-1:0]        temp_val;

  logic [DEB_W-1:0]         hit_cnt_r [ZONE_COUNT];
  logic [DEB_W-1:0]         hit_cnt_nxt [ZONE_COUNT];
  logic signed [VAL_W-1:0]  zval [ZONE_COUNT];
  logic [PW-1:0]            pulse_v;
  logic [1:0]               cur_src;
  logic                     src_en;

  logic                     out_valid_r;
  logic [HIT_W-1:0]         zone_hits_r;
  logic [MAG_W-1:0]         mag_r;
  logic [TEMP_W-1:0]        temp_r;

  function automatic logic [AXIS_W-1:0] axis_scale(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] a17;
    logic [ACC_W:0]        m17;
    logic [23:0]           p;
    a17 = {a[ACC_W-1], a};
    m17 = a[ACC_W-1] ? (ACC_W + 1)'(-a17) : (ACC_W + 1)'(a17);
    p   = 24'(m17) * AXIS_GAIN;
    return p[MAG_SHIFT+AXIS_W-1:MAG_SHIFT];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      prox_r <= in_proximity;
      als_r  <= in_ambient_light;
      ir_r   <= in_infrared;
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      az_r   <= in_accel_z;
      tr_r   <= in_temp_sample;
    end
  end

  always_comb begin
    unique case (cmd.sq_sel)
      AXIS_X:  sq_op = ax_r;
      AXIS_Y:  sq_op = ay_r;
      default: sq_op = az_r;
    endcase
  end

  assign sq_prod = sq_op * sq_op;

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      prod_r <= sq_prod[PROD_W-1:0];
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.sq_acc) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
  end

  assign rad_scaled = RAD_W'(acc_r) * RAD_W'(MAG_SCALE);
  assign tnum       = $signed({{(TNUM_W - ACC_W){tr_r[ACC_W-1]}}, tr_r}) * TEMP_GAIN
                      + TEMP_OFFSET;
  assign tabs       = tnum[TNUM_W-1] ? TNUM_W'(-tnum) : TNUM_W'(tnum);

  assign srem_sh = {srem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign strial  = {2'b00, root_r, 2'b01};
  assign sge     = (srem_sh >= strial);

  assign tq_prod = TQ_PROD_W'(tabs_r[DIV_W-1:2]) * TQ_PROD_W'(TQ_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      rad_r  <= rad_scaled;
      srem_r <= '0;
      root_r <= '0;
      tabs_r <= tabs[DIV_W-1:0];
      tneg_r <= tnum[TNUM_W-1];
      axa_r  <= axis_scale(ax_r);
      aya_r  <= axis_scale(ay_r);
      aza_r  <= axis_scale(az_r);
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      srem_r <= sge ? SREM_W'(srem_sh - strial) : srem_sh[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], sge};
      tq_r   <= tq_prod[TQ_SHIFT+TEMP_W-1:TQ_SHIFT];
    end
  end

  assign mag_val  = root_r[MAG_SHIFT+MAG_W-1:MAG_SHIFT];
  assign temp_q   = tq_r;
  assign temp_val = tneg_r ? (~temp_q + 12'd1) : temp_q;

  assign cur_src = mode_r ? SRC_MOTION : SRC_LIGHT;
  assign src_en  = mode_r ? sensor_enables[EN_BIT_MOTION] : sensor_enables[EN_BIT_LIGHT];

  always_comb begin
    pulse_v = '0;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      logic             active;
      logic             hit;
      logic [DEB_W-1:0] cnt_inc;
      logic signed [VAL_W-1:0] thr;
      active = src_en && zone_set[z].enable && (zone_set[z].source == cur_src);
      thr    = $signed({{(VAL_W - THR_W){1'b0}}, zone_set[z].threshold});
      if (mode_r) begin
        unique case (zone_set[z].channel)
          CH_AX:   zval[z] = $signed({{(VAL_W - AXIS_W){1'b0}}, axa_r});
          CH_AY:   zval[z] = $signed({{(VAL_W - AXIS_W){1'b0}}, aya_r});
          CH_AZ:   zval[z] = $signed({{(VAL_W - AXIS_W){1'b0}}, aza_r});
          CH_TEMP: zval[z] = $signed({{(VAL_W - TEMP_W){temp_val[TEMP_W-1]}}, temp_val});
          default: zval[z] = $signed({{(VAL_W - MAG_W){1'b0}}, mag_val});
        endcase
      end else if (zone_set[z].channel == CH_PROX) begin
        zval[z] = $signed({{(VAL_W - PROX_W){1'b0}}, prox_r});
      end else if (zone_set[z].channel == CH_ALS) begin
        zval[z] = $signed({{(VAL_W - ALS_W){1'b0}}, als_r});
      end else begin
        zval[z] = $signed({{(VAL_W - IR_W){1'b0}}, ir_r});
      end
      priority if (zone_set[z].compare == CMP_LT) begin
        hit = (zval[z] < thr);
      end else if (zone_set[z].compare == CMP_EQ) begin
        hit = (zval[z] == thr);
      end else begin
        hit = (zval[z] > thr);
      end
      cnt_inc = hit ? (hit_cnt_r[z] + 5'd1) : '0;
      if (!active) begin
        hit_cnt_nxt[z] = hit_cnt_r[z];
      end else if (cnt_inc >= hit_debounce) begin
        hit_cnt_nxt[z] = '0;
        pulse_v[z]     = 1'b1;
      end else begin
        hit_cnt_nxt[z] = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        hit_cnt_r[z] <= '0;
      end
    end else if (cmd.eval) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        hit_cnt_r[z] <= hit_cnt_nxt[z];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.eval) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      zone_hits_r <= pulse_v[HIT_W-1:0];
      mag_r       <= mode_r ? mag_val : '0;
      temp_r      <= mode_r ? temp_val : '0;
    end
  end

  assign sts.out_full        = out_valid_r && out_stall;
  assign out_valid           = out_valid_r;
  assign out_zone_hits       = zone_hits_r;
  assign out_magnitude_x100  = mag_r;
  assign out_temperature_x10 = $signed(temp_r);

endmodule

// File: rtl/core/sensor_zone_alarm_qualifier_top.sv
// Top level of the sensor zone alarm qualifier.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid / in_stall   | mode, light readings, motion readings
//   out     | source    | out_valid / out_stall | zone_hits, magnitude_x100, temperature_x10
//   cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A motion item runs, after acceptance, through the sum of squares on the shared
// multiplier, scaling, the bit-pair square root (the temperature reciprocal
// multiply runs alongside) and zone evaluation. A light item goes straight to
// zone evaluation. Reset clears the zone hit counters and loads the register
// defaults. A result waits in the output register; a new item is taken meanwhile
// and holds in evaluation only while that register is still full and stalled.
module sensor_zone_alarm_qualifier_top #(
  parameter int ZONE_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [szaq_pkg::PROX_W-1:0]         in_proximity,
  input  logic [szaq_pkg::ALS_W-1:0]          in_ambient_light,
  input  logic [szaq_pkg::IR_W-1:0]           in_infrared,
  input  logic signed [szaq_pkg::ACC_W-1:0]   in_accel_x,
  input  logic signed [szaq_pkg::ACC_W-1:0]   in_accel_y,
  input  logic signed [szaq_pkg::ACC_W-1:0]   in_accel_z,
  input  logic signed [szaq_pkg::ACC_W-1:0]   in_temp_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [szaq_pkg::HIT_W-1:0]          out_zone_hits,
  output logic [szaq_pkg::MAG_W-1:0]          out_magnitude_x100,
  output logic signed [szaq_pkg::TEMP_W-1:0]  out_temperature_x10,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [$clog2(ZONE_COUNT + 2)-1:0]   cfg_index,
  input  logic [szaq_pkg::CFG_W-1:0]          cfg_data
);
  import szaq_pkg::*;

  localparam int IDX_W = $clog2(ZONE_COUNT + 2);

  zone_set_t [ZONE_COUNT-1:0] zone_set;
  logic [DEB_W-1:0]           hit_debounce;
  logic [EN_W-1:0]            sensor_enables;
  szaq_cmd_t                  cmd;
  szaq_sts_t                  sts;

  szaq_cfg #(
    .ZONE_COUNT (ZONE_COUNT),
    .IDX_W      (IDX_W)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .zone_set       (zone_set),
    .hit_debounce   (hit_debounce),
    .sensor_enables (sensor_enables)
  );

  szaq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  szaq_dp #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .zone_set            (zone_set),
    .hit_debounce        (hit_debounce),
    .sensor_enables      (sensor_enables),
    .in_mode             (in_mode),
    .in_proximity        (in_proximity),
    .in_ambient_light    (in_ambient_light),
    .in_infrared         (in_infrared),
    .in_accel_x          (in_accel_x),
    .in_accel_y          (in_accel_y),
    .in_accel_z          (in_accel_z),
    .in_temp_sample      (in_temp_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_zone_hits       (out_zone_hits),
    .out_magnitude_x100  (out_magnitude_x100),
    .out_temperature_x10 (out_temperature_x10)
  );

endmodule

// File: rtl/core/szaq_checker.sv
// Port-level checker for the sensor zone alarm qualifier, bound to the top level.
module szaq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [szaq_pkg::HIT_W-1:0]          out_zone_hits,
  input logic [szaq_pkg::MAG_W-1:0]          out_magnitude_x100,
  input logic signed [szaq_pkg::TEMP_W-1:0]  out_temperature_x10
);
  import szaq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_zone_hits)
      && $stable(out_magnitude_x100) && $stable(out_temperature_x10))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while an item is in work");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_magnitude_x100 <= MAG_MAX)
    else $error("magnitude beyond its range");

endmodule

bind sensor_zone_alarm_qualifier_top szaq_checker u_szaq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_zone_hits       (out_zone_hits),
  .out_magnitude_x100  (out_magnitude_x100),
  .out_temperature_x10 (out_temperature_x10)
);
